>>> design/euler_zyx_pose_to_transform_core_defines.svh
// assertion macros for the pose to transform core
`ifndef EULER_ZYX_POSE_TO_TRANSFORM_CORE_DEFINES_SVH
`define EULER_ZYX_POSE_TO_TRANSFORM_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define EZP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ezp check failed");

// next-cycle implication, checked during reset too
`define EZP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("ezp check failed");

`endif

>>> design/ezp_pkg.sv
package ezp_pkg;

   localparam int POS_W   = 24;
   localparam int ANG_W   = 15;
   localparam int ROT_W   = 16;
   localparam int REQ_W   = 120;
   localparam int RSP_W   = 216;
   localparam int Z_W     = 26;
   localparam int XY_W    = 33;
   localparam int CS_W    = 32;
   localparam int ANGLE_FRAC_BITS = 6;
   localparam int ROT_FRAC_BITS   = 14;
   localparam int ANG_UNIT_BITS   = 16;
   localparam int INT_FRAC        = 30;
   localparam int CRD_ITERS       = 20;
   localparam int ITERS_PER_STAGE = 2;
   localparam int CRD_STAGES      = CRD_ITERS / ITERS_PER_STAGE;
   localparam int LAT             = CRD_STAGES + 7;

   localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(180 * 65536);
   localparam logic signed [Z_W-1:0] FULL_TURN = Z_W'(360 * 65536);
   localparam logic signed [Z_W-1:0] QTR_TURN  = Z_W'(90 * 65536);
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
   localparam logic signed [ROT_W+2:0] ROT_LIM = (ROT_W+3)'(1 << ROT_FRAC_BITS);

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } crd_type;

   function automatic logic signed [Z_W-1:0] atan_lut(input int i);
      logic signed [Z_W-1:0] r;
      case (i)
         0: r = Z_W'(2949120);
         1: r = Z_W'(1740967);
         2: r = Z_W'(919879);
         3: r = Z_W'(466945);
         4: r = Z_W'(234379);
         5: r = Z_W'(117304);
         6: r = Z_W'(58666);
         7: r = Z_W'(29335);
         8: r = Z_W'(14668);
         9: r = Z_W'(7334);
         10: r = Z_W'(3667);
         11: r = Z_W'(1833);
         12: r = Z_W'(917);
         13: r = Z_W'(458);
         14: r = Z_W'(229);
         15: r = Z_W'(115);
         16: r = Z_W'(57);
         17: r = Z_W'(29);
         18: r = Z_W'(14);
         19: r = Z_W'(7);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic crd_type cordic_iter(input crd_type t, input int i);
      crd_type r;
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      dx = t.y >>> i;
      dy = t.x >>> i;
      if (t.z >= 0) begin
         r.x = t.x - dx;
         r.y = t.y + dy;
         r.z = t.z - atan_lut(i);
      end else begin
         r.x = t.x + dx;
         r.y = t.y - dy;
         r.z = t.z + atan_lut(i);
      end
      return r;
   endfunction

   function automatic logic signed [CS_W-1:0] qround(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd536870912;
      return t[INT_FRAC+CS_W-1:INT_FRAC];
   endfunction

   function automatic logic [ROT_W-1:0] to_out(input logic signed [CS_W+1:0] v);
      logic signed [CS_W+2:0] t;
      logic signed [ROT_W+2:0] s;
      logic signed [ROT_W+2:0] r;
      t = {v[CS_W+1], v} + (CS_W+3)'(1 << (INT_FRAC - ROT_FRAC_BITS - 1));
      s = t[CS_W+2:INT_FRAC-ROT_FRAC_BITS];
      if (s > ROT_LIM) begin
         r = ROT_LIM;
      end else if (s < -ROT_LIM) begin
         r = -ROT_LIM;
      end else begin
         r = s;
      end
      return r[ROT_W-1:0];
   endfunction

endpackage

>>> design/euler_zyx_pose_to_transform_core.sv
// 17 register stages from req word accepted to rsp word valid
// throughput: one pose per cycle while the rsp word is not stalled, set by the 10-stage cordic pipeline
// (two iterations per stage) and the two registered multiply levels
// a stalled rsp word holds the whole pipeline in place
// reset: synchronous active high, clears all stage valid bits
module euler_zyx_pose_to_transform_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // pos_x, pos_y, pos_z, angle_w, angle_p, angle_r, zero fill
   input  logic [ezp_pkg::REQ_W-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // rot_00..rot_22 row major, trans_x, trans_y, trans_z
   output logic [ezp_pkg::RSP_W-1:0] rsp_tdata
);
   import ezp_pkg::*;

   logic                  en;
   logic [LAT-1:0]        v_ff;
   logic [LAT-1:0]        v_in;
   logic [3*POS_W-1:0]    pos_ff [0:LAT-1];
   crd_type               crd_ff [0:CRD_STAGES][0:2];
   crd_type               crd_in [0:CRD_STAGES][0:2];
   logic [2:0]            neg_ff [0:CRD_STAGES];
   logic [2:0]            neg_in;
   logic signed [CS_W-1:0] sin_ff [0:2];
   logic signed [CS_W-1:0] cos_ff [0:2];

   logic signed [63:0] p1_ff [0:9];
   logic signed [CS_W-1:0] sy1_ff, cz1_ff, sz1_ff;
   logic signed [CS_W-1:0] r1_ff [0:9];
   logic signed [CS_W-1:0] sy2_ff, cz2_ff, sz2_ff;
   logic signed [63:0] p2_ff [0:3];
   logic signed [CS_W-1:0] r1b_ff [0:9];
   logic signed [CS_W-1:0] sy3_ff;
   logic signed [CS_W+1:0] e_ff [0:8];
   logic [ROT_W-1:0]       o_ff [0:8];

   assign en         = !v_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = v_ff[LAT-1];
   assign v_in       = {v_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff[0] <= req_tdata[3*POS_W-1:0];
         for (int k = 1; k < LAT; k++) begin
            pos_ff[k] <= pos_ff[k-1];
         end
      end
   end

   // angle reduction into [-90, 90] degrees with fold flag
   always_comb begin
      logic signed [Z_W-1:0] z;
      for (int a = 0; a < 3; a++) begin
         z = Z_W'($signed(req_tdata[3*POS_W+a*ANG_W +: ANG_W])) <<<
             (ANG_UNIT_BITS - ANGLE_FRAC_BITS);
         if (z >= HALF_TURN) begin
            z = z - FULL_TURN;
         end else if (z < -HALF_TURN) begin
            z = z + FULL_TURN;
         end
         neg_in[a] = 1'b0;
         if (z > QTR_TURN) begin
            z = z - HALF_TURN;
            neg_in[a] = 1'b1;
         end else if (z < -QTR_TURN) begin
            z = z + HALF_TURN;
            neg_in[a] = 1'b1;
         end
         crd_in[0][a].x = CORDIC_GAIN;
         crd_in[0][a].y = '0;
         crd_in[0][a].z = z;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         crd_ff[0] <= crd_in[0];
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar g = 0; g < CRD_STAGES; g++) begin : g_crd
      always_comb begin
         crd_type t;
         for (int a = 0; a < 3; a++) begin
            t = crd_ff[g][a];
            for (int j = 0; j < ITERS_PER_STAGE; j++) begin
               t = cordic_iter(t, g * ITERS_PER_STAGE + j);
            end
            crd_in[g+1][a] = t;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            crd_ff[g+1] <= crd_in[g+1];
            neg_ff[g+1] <= neg_ff[g];
         end
      end
   end

   // apply fold sign; index 0 is w (x axis), 1 is p (y), 2 is r (z)
   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            if (neg_ff[CRD_STAGES][a]) begin
               cos_ff[a] <= CS_W'(-crd_ff[CRD_STAGES][a].x);
               sin_ff[a] <= CS_W'(-crd_ff[CRD_STAGES][a].y);
            end else begin
               cos_ff[a] <= CS_W'(crd_ff[CRD_STAGES][a].x);
               sin_ff[a] <= CS_W'(crd_ff[CRD_STAGES][a].y);
            end
         end
      end
   end

   // first product level
   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff[0] <= 64'(sin_ff[1]) * 64'(sin_ff[0]);
         p1_ff[1] <= 64'(sin_ff[1]) * 64'(cos_ff[0]);
         p1_ff[2] <= 64'(cos_ff[2]) * 64'(cos_ff[1]);
         p1_ff[3] <= 64'(sin_ff[2]) * 64'(cos_ff[1]);
         p1_ff[4] <= 64'(cos_ff[1]) * 64'(sin_ff[0]);
         p1_ff[5] <= 64'(cos_ff[1]) * 64'(cos_ff[0]);
         p1_ff[6] <= 64'(sin_ff[2]) * 64'(cos_ff[0]);
         p1_ff[7] <= 64'(sin_ff[2]) * 64'(sin_ff[0]);
         p1_ff[8] <= 64'(cos_ff[2]) * 64'(cos_ff[0]);
         p1_ff[9] <= 64'(cos_ff[2]) * 64'(sin_ff[0]);
         sy1_ff   <= sin_ff[1];
         cz1_ff   <= cos_ff[2];
         sz1_ff   <= sin_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 10; k++) begin
            r1_ff[k] <= qround(p1_ff[k]);
         end
         sy2_ff <= sy1_ff;
         cz2_ff <= cz1_ff;
         sz2_ff <= sz1_ff;
      end
   end

   // second product level on sy*sx and sy*cx
   always_ff @(posedge clock) begin
      if (en) begin
         p2_ff[0] <= 64'(cz2_ff) * 64'(r1_ff[0]);
         p2_ff[1] <= 64'(cz2_ff) * 64'(r1_ff[1]);
         p2_ff[2] <= 64'(sz2_ff) * 64'(r1_ff[0]);
         p2_ff[3] <= 64'(sz2_ff) * 64'(r1_ff[1]);
         r1b_ff   <= r1_ff;
         sy3_ff   <= sy2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff[0] <= (CS_W+2)'(r1b_ff[2]);
         e_ff[1] <= (CS_W+2)'(qround(p2_ff[0])) - (CS_W+2)'(r1b_ff[6]);
         e_ff[2] <= (CS_W+2)'(qround(p2_ff[1])) + (CS_W+2)'(r1b_ff[7]);
         e_ff[3] <= (CS_W+2)'(r1b_ff[3]);
         e_ff[4] <= (CS_W+2)'(qround(p2_ff[2])) + (CS_W+2)'(r1b_ff[8]);
         e_ff[5] <= (CS_W+2)'(qround(p2_ff[3])) - (CS_W+2)'(r1b_ff[9]);
         e_ff[6] <= -(CS_W+2)'(sy3_ff);
         e_ff[7] <= (CS_W+2)'(r1b_ff[4]);
         e_ff[8] <= (CS_W+2)'(r1b_ff[5]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            o_ff[k] <= to_out(e_ff[k]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         rsp_tdata[k*ROT_W +: ROT_W] = o_ff[k];
      end
      rsp_tdata[RSP_W-1:9*ROT_W] = pos_ff[LAT-1];
   end

endmodule

>>> design/ezp_checker.sv
`include "euler_zyx_pose_to_transform_core_defines.svh"

module ezp_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [ezp_pkg::REQ_W-1:0] req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [ezp_pkg::RSP_W-1:0] rsp_tdata
);
   import ezp_pkg::*;

   `EZP_ASSERT_NEXT(a_reset_idle, reset, !rsp_tvalid)
   `EZP_ASSERT_NOW(a_ready_free, !rsp_tvalid, req_tready)
   `EZP_ASSERT_NOW(a_hold_word, $past(rsp_tvalid && !rsp_tready), $stable(rsp_tdata))
   `EZP_ASSERT_NOW(a_rot_range, rsp_tvalid, ($signed(rsp_tdata[ROT_W-1:0]) <= 16384) && ($signed(rsp_tdata[ROT_W-1:0]) >= -16384))

endmodule

bind euler_zyx_pose_to_transform_core ezp_checker u_ezp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/sv/ezp_pose_checker.sv
module ezp_pose_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [ezp_pkg::REQ_W-1:0] req_tdata,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [ezp_pkg::RSP_W-1:0] rsp_tdata,
   output int                        fail_count,
   output int                        pending
);
   import ezp_pkg::*;

   logic [RSP_W-1:0] expected_words[$];

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_shift(longint v, int s);
      if (s == 0) begin
         return v;
      end
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint fix_mul(longint a, longint b);
      return round_shift(a * b, INT_FRAC);
   endfunction

   function automatic longint arctan_step(int i);
      longint tab[20];
      tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
              14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
      return tab[i];
   endfunction

   task automatic angle_sin_cos(input logic [ANG_W-1:0] ang, output longint s,
                                output longint c);
      longint half, full, quarter, z, x, y, dx, dy;
      bit neg;
      half = longint'(180) << ANG_UNIT_BITS;
      full = 2 * half;
      quarter = half / 2;
      z = longint'($signed(ang)) * (longint'(1) << (ANG_UNIT_BITS - ANGLE_FRAC_BITS));
      x = 652032874;
      y = 0;
      neg = 0;
      z = z % full;
      if (z < 0) z += full;
      if (z >= half) z -= full;
      if (z > quarter) begin
         z -= half;
         neg = 1;
      end else if (z < -quarter) begin
         z += half;
         neg = 1;
      end
      for (int i = 0; i < 20; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= arctan_step(i);
         end else begin
            x += dx;
            y -= dy;
            z += arctan_step(i);
         end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endtask

   function automatic logic [ROT_W-1:0] entry_q14(longint v);
      longint lim, r;
      lim = longint'(1) << ROT_FRAC_BITS;
      r = round_shift(v, INT_FRAC - ROT_FRAC_BITS);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[ROT_W-1:0];
   endfunction

   task automatic pose_to_transform(input logic [REQ_W-1:0] w,
                                    output logic [RSP_W-1:0] r);
      longint sx, cx, sy, cy, sz, cz, sysx, sycx;
      angle_sin_cos(w[3*POS_W +: ANG_W], sx, cx);
      angle_sin_cos(w[3*POS_W+ANG_W +: ANG_W], sy, cy);
      angle_sin_cos(w[3*POS_W+2*ANG_W +: ANG_W], sz, cz);
      sysx = fix_mul(sy, sx);
      sycx = fix_mul(sy, cx);
      r = '0;
      r[0*ROT_W +: ROT_W] = entry_q14(fix_mul(cz, cy));
      r[1*ROT_W +: ROT_W] = entry_q14(fix_mul(cz, sysx) - fix_mul(sz, cx));
      r[2*ROT_W +: ROT_W] = entry_q14(fix_mul(cz, sycx) + fix_mul(sz, sx));
      r[3*ROT_W +: ROT_W] = entry_q14(fix_mul(sz, cy));
      r[4*ROT_W +: ROT_W] = entry_q14(fix_mul(sz, sysx) + fix_mul(cz, cx));
      r[5*ROT_W +: ROT_W] = entry_q14(fix_mul(sz, sycx) - fix_mul(cz, sx));
      r[6*ROT_W +: ROT_W] = entry_q14(-sy);
      r[7*ROT_W +: ROT_W] = entry_q14(fix_mul(cy, sx));
      r[8*ROT_W +: ROT_W] = entry_q14(fix_mul(cy, cx));
      r[9*ROT_W +: 3*POS_W] = w[0 +: 3*POS_W];
   endtask

   assign pending = expected_words.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      logic [RSP_W-1:0] exp_word, got_word;
      if (!reset && req_tvalid && req_tready) begin
         pose_to_transform(req_tdata, exp_word);
         expected_words = {expected_words, exp_word};
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_word = rsp_tdata;
         if (expected_words.size() == 0) begin
            $error("unexpected rsp word %h", got_word);
            fail_count++;
         end else begin
            exp_word = expected_words.pop_front();
            for (int f = 0; f < 9; f++) begin
               if (got_word[f*ROT_W +: ROT_W] !== exp_word[f*ROT_W +: ROT_W]) begin
                  $error("rot_%0d%0d expected %h actual %h", f / 3, f % 3,
                         exp_word[f*ROT_W +: ROT_W], got_word[f*ROT_W +: ROT_W]);
                  fail_count++;
               end
            end
            for (int f = 0; f < 3; f++) begin
               if (got_word[9*ROT_W+f*POS_W +: POS_W]
                   !== exp_word[9*ROT_W+f*POS_W +: POS_W]) begin
                  $error("trans_%s expected %h actual %h", f == 0 ? "x" : f == 1 ? "y" : "z",
                         exp_word[9*ROT_W+f*POS_W +: POS_W],
                         got_word[9*ROT_W+f*POS_W +: POS_W]);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

>>> tb/sv/tb_euler_zyx_pose_to_transform_core.sv
module tb_euler_zyx_pose_to_transform_core;
   import ezp_pkg::*;

   localparam int RANDOM_WORDS = 1950;
   localparam longint CYCLE_LIMIT = 200000;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   int               fail_count;
   int               pending;
   longint           cycle_count;
   bit               no_idle;

   euler_zyx_pose_to_transform_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   ezp_pose_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 18);
      end
   end

   function automatic logic [ANG_W-1:0] pick_angle();
      case ($urandom_range(5))
         0: return ANG_W'($urandom);
         1: return ANG_W'($signed(-11520 + 5760 * $urandom_range(4)));
         default: return ANG_W'(int'($urandom_range(23040)) - 11520);
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_pos();
      case ($urandom_range(7))
         0: return 24'h800000;
         1: return 24'h7fffff;
         default: return POS_W'($urandom);
      endcase
   endfunction

   task automatic send_word(input logic [REQ_W-1:0] w, input bit may_idle);
      while (may_idle && !no_idle && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [REQ_W-1:0] pose_word(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                                  logic [POS_W-1:0] pz, logic [ANG_W-1:0] aw,
                                                  logic [ANG_W-1:0] ap, logic [ANG_W-1:0] ar);
      return {{(REQ_W-3*POS_W-3*ANG_W){1'b0}}, ar, ap, aw, pz, py, px};
   endfunction

   initial begin
      int directed[$];
      int drain;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      no_idle = 0;
      directed = '{0, 5760, -5760, 11520, -11520, 2880, -2880, 5761, -5761, 11519,
                   16383, -16384, 23040, 1, -1};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // angle extremes, quarter and half turns, wrap beyond half turn
      foreach (directed[i]) begin
         send_word(pose_word(24'h800000, 24'h7fffff, 24'h000000, ANG_W'(directed[i]),
                             ANG_W'(directed[(i + 5) % directed.size()]),
                             ANG_W'(directed[(i + 9) % directed.size()])), 1'b0);
      end
      send_word(pose_word(24'hffffff, 24'h555555, 24'haaaaaa, 15'h7fff, 15'h4000, 15'h2aaa),
                1'b0);
      send_word(pose_word(24'h000001, 24'haaaaaa, 24'h555555, 15'h0000, 15'h3fff, 15'h5555),
                1'b0);
      req_tvalid <= 1'b0;
      // drain completely before random traffic
      while (pending != 0) @(posedge clock);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         no_idle = (n >= 800 && n < 1100);
         send_word(pose_word(pick_pos(), pick_pos(), pick_pos(), pick_angle(),
                             pick_angle(), pick_angle()), 1'b1);
      end
      req_tvalid <= 1'b0;
      no_idle = 0;
      while (pending != 0) @(posedge clock);
      drain = 0;
      while (drain < 3 * LAT) begin
         @(posedge clock);
         drain++;
      end
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

>>> filelist.f
+incdir+design
design/ezp_pkg.sv
design/euler_zyx_pose_to_transform_core.sv
design/ezp_checker.sv
tb/sv/ezp_pose_checker.sv
tb/sv/tb_euler_zyx_pose_to_transform_core.sv
